>>> rtl/quoted_field_log_tokenizer_top_assert.svh
// Assertion macros shared by the tokenizer modules.
// Each expects signals named clk and rst_n in the module that uses it.
`ifndef QUOTED_FIELD_LOG_TOKENIZER_TOP_ASSERT_SVH
`define QUOTED_FIELD_LOG_TOKENIZER_TOP_ASSERT_SVH

// Same-cycle implication.
`define QFTOK_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qftok assertion failed");

// Next-cycle implication.
`define QFTOK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qftok assertion failed");

`endif

>>> rtl/qftok_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package qftok_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int SPL_W       = 4;
  localparam int SPC_W       = 5;
  localparam logic [SPC_W-1:0] SPACE_SAT = 5'd16;

  // result queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_OFFSET   = 2'd0,
    CFG_SPACE_LIMIT   = 2'd1,
    CFG_TRAILING_LINE = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_TOKEN    = 2'd0,
    KIND_LINE_END = 2'd1,
    KIND_REPORT   = 2'd2
  } item_kind_t;

  // byte codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // bit positions in a bundle's kind mask, emitted in this order
  localparam int KB_TOKEN  = 0;
  localparam int KB_LINE   = 1;
  localparam int KB_REPORT = 2;

  // all results caused by one byte: at most one of each kind
  typedef struct packed {
    logic [2:0]             kinds;
    logic [OFFSET_BITS-1:0] tok_off;
    logic [OFFSET_BITS-1:0] tok_len;
    logic [OFFSET_BITS-1:0] cons;
    logic                   drop;
  } bundle_t;

endpackage
`default_nettype wire

>>> rtl/qftok_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface qftok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;
  modport source(output valid, data_byte, end_of_buffer, input ready);
  modport sink(input valid, data_byte, end_of_buffer, output ready);
endinterface

interface qftok_out_if;
  import qftok_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             item_kind;
  logic [OFFSET_BITS-1:0] token_offset;
  logic [OFFSET_BITS-1:0] token_length;
  logic [OFFSET_BITS-1:0] consumed_offset;
  logic                   tail_dropped;
  logic                   last_of_run;
  modport source(output valid, item_kind, token_offset, token_length, consumed_offset,
                 tail_dropped, last_of_run, input ready);
  modport sink(input valid, item_kind, token_offset, token_length, consumed_offset,
               tail_dropped, last_of_run, output ready);
endinterface

interface qftok_cfg_if;
  import qftok_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/qftok_front.sv
`timescale 1ns / 1ps
`default_nettype none
module qftok_front (
  input  wire logic       clk,
  input  wire logic       rst_n,
  qftok_in_if.sink        in_ch,
  qftok_cfg_if.sink       cfg_ch,
  output qftok_pkg::bundle_t push_data,
  output logic            push_valid,
  input  wire logic       push_ready
);
  import qftok_pkg::*;
  `include "quoted_field_log_tokenizer_top_assert.svh"

  // configuration
  logic [OFFSET_BITS-1:0] base_off_r;
  logic [SPL_W-1:0]       space_limit_r;
  logic                   trailing_line_r;

  // line state
  logic                   at_start_r, at_start_nxt;
  logic [OFFSET_BITS-1:0] byte_pos_r, byte_pos_nxt;
  logic                   token_pending_r, token_pending_nxt;
  logic [OFFSET_BITS-1:0] token_begin_r, token_begin_nxt;
  logic                   quote_open_r, quote_open_nxt;
  logic [SPC_W-1:0]       spaces_seen_r, spaces_seen_nxt;
  logic                   line_tok_r, line_tok_nxt;
  logic [OFFSET_BITS-1:0] line_end_r, line_end_nxt;

  logic                   in_fire;
  logic [OFFSET_BITS-1:0] pos, npos, len_a, len_b;
  logic                   do_close, is_lf;
  bundle_t                bnd;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = push_ready;
  assign in_fire      = in_ch.valid && push_ready;
  assign push_valid   = in_ch.valid && (bnd.kinds != 3'b000);
  assign push_data    = bnd;

  always_comb begin
    pos  = at_start_r ? base_off_r : byte_pos_r;
    npos = pos + 1'b1;
    token_pending_nxt = token_pending_r;
    token_begin_nxt   = token_begin_r;
    quote_open_nxt    = quote_open_r;
    spaces_seen_nxt   = spaces_seen_r;
    line_tok_nxt      = line_tok_r;
    line_end_nxt      = at_start_r ? base_off_r : line_end_r;
    at_start_nxt      = 1'b0;
    byte_pos_nxt      = npos;
    do_close          = 1'b0;
    is_lf             = 1'b0;
    bnd               = '0;
    len_a             = pos - token_begin_r;

    case (in_ch.data_byte)
      CH_SPACE: begin
        if (!quote_open_r) begin
          if (spaces_seen_r < SPACE_SAT) begin
            spaces_seen_nxt = spaces_seen_r + 1'b1;
          end
          if (spaces_seen_nxt <= {1'b0, space_limit_r}) begin
            do_close = 1'b1;
          end else if (!token_pending_r) begin
            token_pending_nxt = 1'b1;
            token_begin_nxt   = pos;
          end
        end
      end
      CH_QUOTE: begin
        quote_open_nxt = !quote_open_r;
        if (!quote_open_r) begin
          token_pending_nxt = 1'b1;
          token_begin_nxt   = npos;
        end else begin
          do_close = 1'b1;
        end
      end
      CH_LF: begin
        if (!quote_open_r) begin
          do_close = 1'b1;
          is_lf    = 1'b1;
        end
      end
      CH_COMMA, CH_CR, CH_TAB: begin
        if (!quote_open_r) begin
          do_close = 1'b1;
        end
      end
      default: begin
        if (!token_pending_r) begin
          token_pending_nxt = 1'b1;
          token_begin_nxt   = pos;
        end
      end
    endcase

    // close the open token at the current byte
    if (do_close) begin
      if (token_pending_r && (len_a != '0)) begin
        bnd.kinds[KB_TOKEN] = 1'b1;
        bnd.tok_off         = token_begin_r;
        bnd.tok_len         = len_a;
        line_tok_nxt        = 1'b1;
      end
      token_pending_nxt = 1'b0;
    end

    if (is_lf) begin
      bnd.kinds[KB_LINE] = line_tok_nxt;
      line_tok_nxt       = 1'b0;
      spaces_seen_nxt    = '0;
      line_end_nxt       = npos;
    end

    len_b = npos - token_begin_nxt;
    if (in_ch.end_of_buffer) begin
      if (trailing_line_r) begin
        if (token_pending_nxt && (len_b != '0)) begin
          bnd.kinds[KB_TOKEN] = 1'b1;
          bnd.tok_off         = token_begin_nxt;
          bnd.tok_len         = len_b;
          line_tok_nxt        = 1'b1;
        end
        if (line_tok_nxt) begin
          bnd.kinds[KB_LINE] = 1'b1;
        end
      end else begin
        bnd.kinds[KB_REPORT] = 1'b1;
        bnd.cons             = line_end_nxt;
        bnd.drop             = line_tok_nxt;
      end
      // clear for the next buffer
      at_start_nxt      = 1'b1;
      token_pending_nxt = 1'b0;
      token_begin_nxt   = '0;
      quote_open_nxt    = 1'b0;
      spaces_seen_nxt   = '0;
      line_tok_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_off_r      <= '0;
      space_limit_r   <= 4'd3;
      trailing_line_r <= 1'b1;
      at_start_r      <= 1'b1;
      token_pending_r <= 1'b0;
      token_begin_r   <= '0;
      quote_open_r    <= 1'b0;
      spaces_seen_r   <= '0;
      line_tok_r      <= 1'b0;
      byte_pos_r      <= '0;
      line_end_r      <= '0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_BASE_OFFSET:   base_off_r      <= cfg_ch.data[OFFSET_BITS-1:0];
          CFG_SPACE_LIMIT:   space_limit_r   <= cfg_ch.data[SPL_W-1:0];
          CFG_TRAILING_LINE: trailing_line_r <= cfg_ch.data[0];
          default: ;
        endcase
      end
      if (in_fire) begin
        at_start_r      <= at_start_nxt;
        byte_pos_r      <= byte_pos_nxt;
        token_pending_r <= token_pending_nxt;
        token_begin_r   <= token_begin_nxt;
        quote_open_r    <= quote_open_nxt;
        spaces_seen_r   <= spaces_seen_nxt;
        line_tok_r      <= line_tok_nxt;
        line_end_r      <= line_end_nxt;
      end
    end
  end

  // an open quote always carries a pending token
  `QFTOK_ASSERT_IMP(a_quote_pending, quote_open_r, token_pending_r)
  `QFTOK_ASSERT_IMP(a_space_sat, 1'b1, spaces_seen_r <= SPACE_SAT)

endmodule
`default_nettype wire

>>> rtl/qftok_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module qftok_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire qftok_pkg::bundle_t push_data,
  input  wire logic          push_valid,
  output logic               push_ready,
  output qftok_pkg::bundle_t head_data,
  output logic               head_valid,
  input  wire logic          pop
);
  import qftok_pkg::*;
  `include "quoted_field_log_tokenizer_top_assert.svh"

  bundle_t           entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push_fire, pop_fire;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = entry_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push_fire, pop_fire})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `QFTOK_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= QCNT_W'(QDEPTH))
  `QFTOK_ASSERT_NEXT(a_cnt_grow, push_fire && !pop_fire, cnt_r == $past(cnt_r) + 1'b1)

endmodule
`default_nettype wire

>>> rtl/qftok_back.sv
`timescale 1ns / 1ps
`default_nettype none
module qftok_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire qftok_pkg::bundle_t head_data,
  input  wire logic          head_valid,
  output logic               pop,
  qftok_out_if.source        out_ch
);
  import qftok_pkg::*;
  `include "quoted_field_log_tokenizer_top_assert.svh"

  logic [2:0]             done_r;
  logic [2:0]             remain, sel;
  logic                   is_last, load;
  logic                   out_valid_r;
  item_kind_t             kind_r;
  logic [OFFSET_BITS-1:0] tok_off_r, tok_len_r, cons_r;
  logic                   drop_r, last_r;

  assign remain  = head_data.kinds & ~done_r;
  // emit token, then line end, then report
  assign sel     = remain & (~remain + 3'd1);
  assign is_last = ((remain & ~sel) == 3'b000);
  assign load    = head_valid && (!out_valid_r || out_ch.ready);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      done_r      <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        done_r      <= is_last ? 3'b000 : (done_r | sel);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_off_r <= '0;
      tok_len_r <= '0;
      cons_r    <= '0;
      drop_r    <= 1'b0;
      last_r    <= is_last;
      if (sel[KB_TOKEN]) begin
        kind_r    <= KIND_TOKEN;
        tok_off_r <= head_data.tok_off;
        tok_len_r <= head_data.tok_len;
      end else if (sel[KB_LINE]) begin
        kind_r <= KIND_LINE_END;
      end else begin
        kind_r <= KIND_REPORT;
        cons_r <= head_data.cons;
        drop_r <= head_data.drop;
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.item_kind       = kind_r;
  assign out_ch.token_offset    = tok_off_r;
  assign out_ch.token_length    = tok_len_r;
  assign out_ch.consumed_offset = cons_r;
  assign out_ch.tail_dropped    = drop_r;
  assign out_ch.last_of_run     = last_r;

  // the head bundle always has an item left to send
  `QFTOK_ASSERT_IMP(a_head_remain, head_valid, remain != 3'b000)

endmodule
`default_nettype wire

>>> rtl/quoted_field_log_tokenizer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Quoted-field line tokenizer. Feed a text buffer one byte per word on in_ch,
// with end_of_buffer set on its final byte; out_ch returns tokens (absolute
// start offset and length), line-end items and, in incremental mode, a
// buffer-end report carrying the offset after the last complete line and a
// flag for withdrawn tokens of the unfinished tail. Every byte that causes
// results marks its final one with last_of_run. Throughput: one byte per
// cycle on the input and, while out_ch is ready, one result per cycle on the
// output, so a stream runs at one byte per cycle as long as results average
// no more than one per byte. The front classifies each byte combinationally
// and packs all of its results (at most three) into one bundle; a four-bundle
// queue decouples it from the back, which sends one item of a bundle per
// cycle through an output register. Input stalls only when that queue is
// full. Results pass the queue, then the output register. Registers on cfg_ch
// (0 buffer start offset, 1 space split limit, 2 trailing-line flush, others
// ignored) are always ready and must be written while the block is idle; a
// new start offset is taken at the first byte of the next buffer.
module quoted_field_log_tokenizer_top (
  input  wire logic    clk,
  input  wire logic    rst_n,
  qftok_in_if.sink     in_ch,
  qftok_out_if.source  out_ch,
  qftok_cfg_if.sink    cfg_ch
);
  import qftok_pkg::*;

  // front to queue
  bundle_t push_data;
  logic    push_valid;
  logic    push_ready;

  // queue to back
  bundle_t head_data;
  logic    head_valid;
  logic    pop;

  // classify bytes, hold line state and registers
  qftok_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // hold bundles while the output side stalls
  qftok_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .head_data  (head_data),
    .head_valid (head_valid),
    .pop        (pop)
  );

  // split each bundle into single result words
  qftok_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_data  (head_data),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire
